### rtl/jfs_pkg.sv
// jfs_pkg: beat types and marker codes for the jpeg frame size scanner
// used by jfs_scan_core and jpeg_frame_size_scanner; no dependencies
`default_nettype none

package jfs_pkg;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} jfs_in_t;

	typedef struct packed {
		logic        found;
		logic [15:0] width;
		logic [15:0] height;
	} jfs_out_t;

	// per-byte status from the scan core
	typedef struct packed {
		logic res_valid;
		logic at_start;
	} jfs_stat_t;

	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] MARK_SOI    = 8'hD8;
	localparam logic [7:0] SOF_FIRST   = 8'hC0;
	localparam logic [7:0] SOF_LAST    = 8'hCF;
	localparam logic [7:0] MARK_DHT    = 8'hC4;
	localparam logic [7:0] MARK_JPG    = 8'hC8;
	localparam logic [7:0] MARK_DAC    = 8'hCC;

	function automatic logic is_frame_code(input logic [7:0] code);
		return (code >= SOF_FIRST) && (code <= SOF_LAST) && (code != MARK_DHT)
			&& (code != MARK_JPG) && (code != MARK_DAC);
	endfunction

endpackage

`default_nettype wire

### rtl/jfs_scan_core.sv
// jfs_scan_core: segment walker, one byte per step, holds the parse state
// depends on jfs_pkg
`default_nettype none

module jfs_scan_core
	import jfs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire jfs_in_t   beat,
	output jfs_stat_t      stat,
	output jfs_out_t       res
);

	typedef enum logic [3:0] {
		PH_START0, PH_START1, PH_MARK_FF, PH_MARK_CODE, PH_LEN_HI, PH_LEN_LO,
		PH_SKIP, PH_FLEN_HI, PH_FLEN_LO, PH_PREC, PH_H_HI, PH_H_LO, PH_W_HI, PH_W_LO
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  width_hi_q, width_hi_d;
	logic        finished_q, finished_d;

	logic        fail, ok;
	logic [15:0] seg_len;

	assign seg_len = {len_hi_q, beat.byte_value};

	always_comb begin
		phase_d    = phase_q;
		skip_d     = skip_q;
		len_hi_d   = len_hi_q;
		height_d   = height_q;
		width_hi_d = width_hi_q;
		finished_d = finished_q;
		fail       = 1'b0;
		ok         = 1'b0;
		if (!finished_q) begin
			unique case (phase_q)
				PH_START0: begin
					if (beat.byte_value == MARK_PREFIX) phase_d = PH_START1;
					else fail = 1'b1;
				end
				PH_START1: begin
					if (beat.byte_value == MARK_SOI) phase_d = PH_MARK_FF;
					else fail = 1'b1;
				end
				PH_MARK_FF: begin
					if (beat.byte_value == MARK_PREFIX) phase_d = PH_MARK_CODE;
					else fail = 1'b1;
				end
				PH_MARK_CODE: begin
					phase_d = is_frame_code(beat.byte_value) ? PH_FLEN_HI : PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_hi_d = beat.byte_value;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (seg_len < 16'd2) begin
						fail = 1'b1;
					end else begin
						skip_d  = seg_len - 16'd2;
						// length of two means an empty payload
						phase_d = (seg_len == 16'd2) ? PH_MARK_FF : PH_SKIP;
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - 16'd1;
					if (skip_q == 16'd1) phase_d = PH_MARK_FF;
				end
				PH_FLEN_HI: phase_d = PH_FLEN_LO;
				PH_FLEN_LO: phase_d = PH_PREC;
				PH_PREC:    phase_d = PH_H_HI;
				PH_H_HI: begin
					height_d = {beat.byte_value, 8'd0};
					phase_d  = PH_H_LO;
				end
				PH_H_LO: begin
					height_d = height_q | {8'd0, beat.byte_value};
					phase_d  = PH_W_HI;
				end
				PH_W_HI: begin
					width_hi_d = beat.byte_value;
					phase_d    = PH_W_LO;
				end
				PH_W_LO: begin
					// width low byte on the last beat counts as not found
					if (beat.last_byte) fail = 1'b1;
					else ok = 1'b1;
				end
				default: fail = 1'b1;
			endcase
			if (beat.last_byte) fail = ~ok;
			if (fail || ok) finished_d = 1'b1;
		end
		if (beat.last_byte) begin
			phase_d    = PH_START0;
			skip_d     = '0;
			len_hi_d   = '0;
			height_d   = '0;
			width_hi_d = '0;
			finished_d = 1'b0;
		end
	end

	assign stat.res_valid = step && !finished_q && (fail || ok);
	assign stat.at_start  = (phase_q == PH_START0) && !finished_q;
	assign res.found      = ok;
	assign res.width      = ok ? {width_hi_q, beat.byte_value} : 16'd0;
	assign res.height     = ok ? height_q : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START0;
			skip_q     <= '0;
			len_hi_q   <= '0;
			height_q   <= '0;
			width_hi_q <= '0;
			finished_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			skip_q     <= skip_d;
			len_hi_q   <= len_hi_d;
			height_q   <= height_d;
			width_hi_q <= width_hi_d;
			finished_q <= finished_d;
		end
	end

endmodule

`default_nettype wire

### rtl/jpeg_frame_size_scanner.sv
// Scans a JPEG byte stream for the start-of-frame marker and reports the frame
// height and width once per file (found=0 on a bad start, a bad marker or end of
// file). One byte beat is taken every clock cycle unless back-pressure stalls
// the byte side; a byte is held in an input register, parsed against the segment
// state when it leaves that register, and its result, if any, lands in the output
// register. Back-pressure on the result side stalls the byte side only while the
// output register is full and not being taken.
// depends on jfs_pkg and jfs_scan_core
`default_nettype none

module jpeg_frame_size_scanner
	import jfs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    byte_valid,
	output logic         byte_ready,
	input  wire jfs_in_t byte_data,
	output logic         size_valid,
	input  wire logic    size_ready,
	output jfs_out_t     size_data
);

	logic      valid_s1;
	jfs_in_t   data_s1;
	logic      advance;
	jfs_stat_t stat;
	jfs_out_t  res;
	logic      size_valid_q;
	jfs_out_t  size_data_q;

	assign advance    = valid_s1 && (!size_valid_q || size_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= byte_data;
		end
	end

	jfs_scan_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (data_s1),
		.stat   (stat),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_valid_q <= 1'b0;
		end else if (stat.res_valid) begin
			size_valid_q <= 1'b1;
		end else if (size_ready) begin
			size_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid) begin
			size_data_q <= res;
		end
	end

	assign size_valid = size_valid_q;
	assign size_data  = size_data_q;

`ifndef SYNTH
	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid |-> (!size_valid_q || size_ready))
		else $error("result register overwritten");

	// a last-byte beat returns the parser to the start of a file
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && data_s1.last_byte) |=> stat.at_start)
		else $error("parser not back at start after last byte");

	// not-found results carry zero size
	a_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		(size_valid_q && !size_data_q.found) |-> (size_data_q.width == 16'd0
			&& size_data_q.height == 16'd0))
		else $error("nonzero size on not-found result");

	// the byte side stalls only with a beat parked in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (valid_s1 && size_valid_q && !size_ready))
		else $error("byte side stalled without cause");
`endif

endmodule

`default_nettype wire

### test/tb_jpeg_frame_size_scanner.sv
// testbench for jpeg_frame_size_scanner: streams jpeg files, some cut short, byte by
// byte and checks each frame size result against a predictor of the marker walk
// depends on jfs_pkg and the rtl of jpeg_frame_size_scanner
`timescale 1ns / 1ps

module tb_jpeg_frame_size_scanner
	import jfs_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 150;
	localparam int DRAIN_WAIT  = 20;

	typedef enum logic [3:0] {
		S_SOI_FF, S_SOI_D8, S_SEG_FF, S_SEG_CODE, S_LEN_HI, S_LEN_LO, S_SKIP,
		S_FLEN_HI, S_FLEN_LO, S_PREC, S_H_HI, S_H_LO, S_W_HI, S_W_LO
	} scan_state_t;

	logic     clk        = 1'b0;
	logic     arst_n     = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_ready;
	jfs_in_t  byte_data  = '0;
	logic     size_valid;
	logic     size_ready = 1'b0;
	jfs_out_t size_data;

	jpeg_frame_size_scanner uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.size_valid (size_valid),
		.size_ready (size_ready),
		.size_data  (size_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	jfs_in_t    pending_bytes[$];
	jfs_out_t   size_expect[$];
	logic [7:0] file_bytes[$];
	int         queued_bytes  = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         stalls_asked  = 0;
	int         stalls_taken  = 0;
	int         stall_left    = 0;
	int         cycle_count   = 0;
	int         mismatches    = 0;
	jfs_out_t   size_want;

	// predictor state for the file currently being scanned
	scan_state_t scan_state  = S_SOI_FF;
	logic [15:0] skip_left   = '0;
	logic [7:0]  len_hi      = '0;
	logic [15:0] height_acc  = '0;
	logic [7:0]  width_hi    = '0;
	logic        file_done   = 1'b0;

	function automatic logic sof_marker(input logic [7:0] code);
		if (code < SOF_FIRST || code > SOF_LAST)
			return 1'b0;
		return !(code == MARK_DHT || code == MARK_JPG || code == MARK_DAC);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic scan_clear();
		scan_state = S_SOI_FF;
		skip_left  = '0;
		len_hi     = '0;
		height_acc = '0;
		width_hi   = '0;
		file_done  = 1'b0;
	endtask

	task automatic scan_byte(input jfs_in_t beat);
		logic [7:0]  b;
		logic [15:0] seg_len;
		logic [15:0] w;
		logic        failed;
		logic        hit;
		jfs_out_t    res;
		b = beat.byte_value;
		w = '0;
		failed = 1'b0;
		hit = 1'b0;
		// once the file has its result, only the last flag matters
		if (file_done) begin
			if (beat.last_byte)
				scan_clear();
			return;
		end
		case (scan_state)
			S_SOI_FF: begin
				if (b == MARK_PREFIX) scan_state = S_SOI_D8;
				else failed = 1'b1;
			end
			S_SOI_D8: begin
				if (b == MARK_SOI) scan_state = S_SEG_FF;
				else failed = 1'b1;
			end
			S_SEG_FF: begin
				if (b == MARK_PREFIX) scan_state = S_SEG_CODE;
				else failed = 1'b1;
			end
			S_SEG_CODE: scan_state = sof_marker(b) ? S_FLEN_HI : S_LEN_HI;
			S_LEN_HI: begin
				len_hi = b;
				scan_state = S_LEN_LO;
			end
			S_LEN_LO: begin
				seg_len = {len_hi, b};
				if (seg_len < 16'd2) begin
					failed = 1'b1;
				end else begin
					skip_left = seg_len - 16'd2;
					scan_state = (skip_left == 16'd0) ? S_SEG_FF : S_SKIP;
				end
			end
			S_SKIP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					scan_state = S_SEG_FF;
			end
			S_FLEN_HI: scan_state = S_FLEN_LO;
			S_FLEN_LO: scan_state = S_PREC;
			S_PREC: scan_state = S_H_HI;
			S_H_HI: begin
				height_acc = {b, 8'h00};
				scan_state = S_H_LO;
			end
			S_H_LO: begin
				height_acc[7:0] = b;
				scan_state = S_W_HI;
			end
			S_W_HI: begin
				width_hi = b;
				scan_state = S_W_LO;
			end
			S_W_LO: begin
				w = {width_hi, b};
				// a frame cut off right at the width counts as not found
				if (beat.last_byte) failed = 1'b1;
				else hit = 1'b1;
			end
			default: failed = 1'b1;
		endcase
		if (!failed && !hit && !beat.last_byte)
			return;
		res.found  = hit;
		res.width  = hit ? w : 16'd0;
		res.height = hit ? height_acc : 16'd0;
		size_expect.push_back(res);
		if (beat.last_byte)
			scan_clear();
		else
			file_done = 1'b1;
	endtask

	// byte side: offer the next pending byte, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
		end else begin
			if (byte_valid && byte_ready)
				scan_byte(byte_data);
			if (!byte_valid || byte_ready) begin
				if (pending_bytes.size() == 0 || $urandom_range(99) < send_idle_pct) begin
					byte_valid <= 1'b0;
				end else begin
					byte_data <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
				end
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_ready <= 1'b0;
			stall_left <= 0;
			stalls_taken <= 0;
		end else if (stall_left != 0) begin
			size_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stalls_taken != stalls_asked) begin
			size_ready <= 1'b0;
			stall_left <= LONG_STALL;
			stalls_taken <= stalls_taken + 1;
		end else begin
			size_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && size_valid && size_ready) begin
			if (size_expect.size() == 0) begin
				report_mismatch($sformatf("result with none expected: found %0d w %0d h %0d",
					size_data.found, size_data.width, size_data.height));
			end else begin
				size_want = size_expect.pop_front();
				if (size_data.found !== size_want.found)
					report_mismatch($sformatf("found %b, want %b",
						size_data.found, size_want.found));
				if (size_data.width !== size_want.width)
					report_mismatch($sformatf("width %0d, want %0d",
						size_data.width, size_want.width));
				if (size_data.height !== size_want.height)
					report_mismatch($sformatf("height %0d, want %0d",
						size_data.height, size_want.height));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_file(input int keep);
		jfs_in_t item;
		for (int i = 0; i < keep; i++) begin
			item.byte_value = file_bytes[i];
			item.last_byte  = (i == keep - 1);
			pending_bytes.push_back(item);
		end
		queued_bytes += keep;
	endtask

	task automatic add_segment(input logic [7:0] code, input int seg_len, input bit good_prefix);
		logic [15:0] len16;
		len16 = 16'(seg_len);
		file_bytes.push_back(good_prefix ? MARK_PREFIX : rand_byte());
		file_bytes.push_back(code);
		file_bytes.push_back(len16[15:8]);
		file_bytes.push_back(len16[7:0]);
		for (int i = 2; i < seg_len; i++)
			file_bytes.push_back(rand_byte());
	endtask

	task automatic add_frame(input logic [7:0] code, input logic [15:0] h, input logic [15:0] w,
			input int trail);
		file_bytes.push_back(MARK_PREFIX);
		file_bytes.push_back(code);
		repeat (3) file_bytes.push_back(rand_byte());
		file_bytes.push_back(h[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(w[7:0]);
		repeat (trail) file_bytes.push_back(rand_byte());
	endtask

	function automatic logic [7:0] rand_other_code();
		logic [7:0] code;
		case ($urandom_range(9))
			0: return MARK_DHT;
			1: return MARK_JPG;
			2: return MARK_DAC;
			default: begin
				code = rand_byte();
				while (sof_marker(code))
					code = rand_byte();
				return code;
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_sof_code();
		logic [7:0] code;
		code = SOF_FIRST | 8'($urandom_range(15));
		while (!sof_marker(code))
			code = SOF_FIRST | 8'($urandom_range(15));
		return code;
	endfunction

	function automatic logic [15:0] rand_dim();
		case ($urandom_range(6))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic queue_random_file();
		int kind;
		int r;
		int seg_len;
		int keep;
		file_bytes = {};
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 12)) file_bytes.push_back(rand_byte());
		end else begin
			file_bytes.push_back(kind < 11 ? rand_byte() : MARK_PREFIX);
			file_bytes.push_back(kind < 14 ? rand_byte() : MARK_SOI);
			repeat ($urandom_range(0, 3)) begin
				r = $urandom_range(99);
				if (r < 5) seg_len = $urandom_range(0, 1);
				else if (r < 15) seg_len = 2;
				else if (r < 20) seg_len = $urandom_range(40, 90);
				else seg_len = $urandom_range(3, 12);
				add_segment(rand_other_code(), seg_len, $urandom_range(99) >= 4);
			end
			// some files carry no frame at all and run into their end
			if (kind >= 20)
				add_frame(rand_sof_code(), rand_dim(), rand_dim(),
					($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4));
			else
				repeat ($urandom_range(0, 3)) file_bytes.push_back(rand_byte());
		end
		keep = file_bytes.size();
		if ($urandom_range(99) < 12)
			keep = $urandom_range(1, file_bytes.size());
		queue_file(keep);
	endtask

	task automatic queue_random_stretch();
		int start_bytes;
		int files;
		start_bytes = queued_bytes;
		files = 0;
		while (queued_bytes - start_bytes < 60 || files < 3) begin
			queue_random_file();
			files++;
		end
	endtask

	task automatic wait_until_drained();
		while (pending_bytes.size() != 0 || byte_valid || size_expect.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 18;
		recv_idle_pct = 71;

		// end of file on the very first byte
		file_bytes = {MARK_PREFIX};
		queue_file(1);
		// bad start on either byte, trailing bytes ignored
		file_bytes = {8'h00, MARK_PREFIX, MARK_SOI};
		queue_file(3);
		file_bytes = {MARK_PREFIX, 8'hD9, 8'h11};
		queue_file(3);
		file_bytes = {MARK_PREFIX, MARK_SOI};
		queue_file(2);
		// smallest and largest frame sizes
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_frame(SOF_FIRST, 16'h0000, 16'h0000, 1);
		queue_file(file_bytes.size());
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_frame(SOF_LAST, 16'hFFFF, 16'hFFFF, 3);
		queue_file(file_bytes.size());
		// width low byte is the last byte
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_frame(8'hC2, 16'h0123, 16'h0456, 0);
		queue_file(file_bytes.size());
		// empty segment, then a frame
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_segment(8'hE0, 2, 1'b1);
		add_frame(8'hC5, 16'h00F0, 16'h0140, 2);
		queue_file(file_bytes.size());
		// segment lengths below two
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_segment(8'hE1, 0, 1'b1);
		add_frame(8'hC1, 16'h1111, 16'h2222, 1);
		queue_file(file_bytes.size());
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_segment(8'hDB, 1, 1'b1);
		queue_file(file_bytes.size());
		// missing prefix before a marker
		file_bytes = {MARK_PREFIX, MARK_SOI, 8'h12, 8'hC0, 8'h00};
		queue_file(file_bytes.size());
		// codes inside the frame range that are not frames, and a prefix code
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_segment(MARK_DHT, 5, 1'b1);
		add_segment(MARK_JPG, 3, 1'b1);
		add_segment(MARK_DAC, 4, 1'b1);
		add_segment(MARK_PREFIX, 4, 1'b1);
		add_frame(8'hC3, 16'h8001, 16'h7FFE, 2);
		queue_file(file_bytes.size());
		// skip across a length with a nonzero high byte
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_segment(8'hFE, 16'h0104, 1'b1);
		add_frame(8'hCF, 16'h0400, 16'h0300, 1);
		queue_file(file_bytes.size());
		// end of file inside a skip and inside a frame header
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_segment(8'hFE, 20, 1'b1);
		queue_file(10);
		file_bytes = {MARK_PREFIX, MARK_SOI};
		add_frame(8'hC6, 16'h5555, 16'hAAAA, 2);
		queue_file(8);

		queue_random_stretch();
		wait_until_drained();

		@(negedge clk);
		send_idle_pct = 71;
		recv_idle_pct = 18;
		queue_random_stretch();
		wait_until_drained();

		// full rate, with one long hold-off on the result side to back up the byte side
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stalls_asked = stalls_asked + 1;
		queue_random_stretch();
		wait_until_drained();

		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && size_expect.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
rtl/jfs_pkg.sv
rtl/jfs_scan_core.sv
rtl/jpeg_frame_size_scanner.sv
test/tb_jpeg_frame_size_scanner.sv
